// ===== rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg: shared types and constants for the sha-256 digest block
// Holds the controller-to-datapath command bundle, the byte source codes for
// the message window, the initial hash values and the round constant table.
// ----------------------------------------------------------------------------
package sha256_pkg;

    // byte source for the message window
    localparam logic [1:0] SEL_DATA = 2'd0;
    localparam logic [1:0] SEL_MARK = 2'd1;
    localparam logic [1:0] SEL_ZERO = 2'd2;
    localparam logic [1:0] SEL_LEN  = 2'd3;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_INDEX = 3'd7;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic       shift_en;   // shift one byte into the message window
        logic [1:0] byte_sel;   // source of that byte
        logic       cnt_inc;    // count one message byte
        logic       load_vars;  // a..h <= hash words
        logic       round_en;   // run one compression round
        logic       hash_add;   // hash words += a..h
        logic       restart;    // back to initial hash and zero length
        logic [5:0] round_idx;  // current round
        logic [2:0] pos_lo;     // low bits of fill position, picks length byte
        logic [2:0] out_idx;    // digest word on the output
    } sha256_cmd_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        case (idx)
            6'd0:  round_const = 32'h428a2f98;
            6'd1:  round_const = 32'h71374491;
            6'd2:  round_const = 32'hb5c0fbcf;
            6'd3:  round_const = 32'he9b5dba5;
            6'd4:  round_const = 32'h3956c25b;
            6'd5:  round_const = 32'h59f111f1;
            6'd6:  round_const = 32'h923f82a4;
            6'd7:  round_const = 32'hab1c5ed5;
            6'd8:  round_const = 32'hd807aa98;
            6'd9:  round_const = 32'h12835b01;
            6'd10: round_const = 32'h243185be;
            6'd11: round_const = 32'h550c7dc3;
            6'd12: round_const = 32'h72be5d74;
            6'd13: round_const = 32'h80deb1fe;
            6'd14: round_const = 32'h9bdc06a7;
            6'd15: round_const = 32'hc19bf174;
            6'd16: round_const = 32'he49b69c1;
            6'd17: round_const = 32'hefbe4786;
            6'd18: round_const = 32'h0fc19dc6;
            6'd19: round_const = 32'h240ca1cc;
            6'd20: round_const = 32'h2de92c6f;
            6'd21: round_const = 32'h4a7484aa;
            6'd22: round_const = 32'h5cb0a9dc;
            6'd23: round_const = 32'h76f988da;
            6'd24: round_const = 32'h983e5152;
            6'd25: round_const = 32'ha831c66d;
            6'd26: round_const = 32'hb00327c8;
            6'd27: round_const = 32'hbf597fc7;
            6'd28: round_const = 32'hc6e00bf3;
            6'd29: round_const = 32'hd5a79147;
            6'd30: round_const = 32'h06ca6351;
            6'd31: round_const = 32'h14292967;
            6'd32: round_const = 32'h27b70a85;
            6'd33: round_const = 32'h2e1b2138;
            6'd34: round_const = 32'h4d2c6dfc;
            6'd35: round_const = 32'h53380d13;
            6'd36: round_const = 32'h650a7354;
            6'd37: round_const = 32'h766a0abb;
            6'd38: round_const = 32'h81c2c92e;
            6'd39: round_const = 32'h92722c85;
            6'd40: round_const = 32'ha2bfe8a1;
            6'd41: round_const = 32'ha81a664b;
            6'd42: round_const = 32'hc24b8b70;
            6'd43: round_const = 32'hc76c51a3;
            6'd44: round_const = 32'hd192e819;
            6'd45: round_const = 32'hd6990624;
            6'd46: round_const = 32'hf40e3585;
            6'd47: round_const = 32'h106aa070;
            6'd48: round_const = 32'h19a4c116;
            6'd49: round_const = 32'h1e376c08;
            6'd50: round_const = 32'h2748774c;
            6'd51: round_const = 32'h34b0bcb5;
            6'd52: round_const = 32'h391c0cb3;
            6'd53: round_const = 32'h4ed8aa4a;
            6'd54: round_const = 32'h5b9cca4f;
            6'd55: round_const = 32'h682e6ff3;
            6'd56: round_const = 32'h748f82ee;
            6'd57: round_const = 32'h78a5636f;
            6'd58: round_const = 32'h84c87814;
            6'd59: round_const = 32'h8cc70208;
            6'd60: round_const = 32'h90befffa;
            6'd61: round_const = 32'ha4506ceb;
            6'd62: round_const = 32'hbef9a3f7;
            default: round_const = 32'hc67178f2;
        endcase
    endfunction

endpackage

// ===== rtl/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha256_ctrl: sequencer for the sha-256 digest block
// Takes input requests, walks the padding bytes, counts the 64 rounds of each
// compression and steps the eight digest words out.
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_valid,
    input  logic                    s_has_byte,
    input  logic                    s_last,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output sha256_pkg::sha256_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] pos_reg, pos_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] out_reg, out_next;
    logic       last_reg, last_next;
    logic       mark_reg, mark_next;
    logic       len_ok_reg, len_ok_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            round_reg  <= '0;
            out_reg    <= '0;
            last_reg   <= 1'b0;
            mark_reg   <= 1'b0;
            len_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            round_reg  <= round_next;
            out_reg    <= out_next;
            last_reg   <= last_next;
            mark_reg   <= mark_next;
            len_ok_reg <= len_ok_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        round_next    = round_reg;
        out_next      = out_reg;
        last_next     = last_reg;
        mark_next     = mark_reg;
        len_ok_next   = len_ok_reg;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd           = '0;
        cmd.round_idx = round_reg;
        cmd.pos_lo    = pos_reg[2:0];
        cmd.out_idx   = out_reg;
        cmd.byte_sel  = sha256_pkg::SEL_DATA;

        case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    last_next = s_last;
                    if (s_has_byte)
                    begin
                        cmd.shift_en = 1'b1;
                        cmd.cnt_inc  = 1'b1;
                        pos_next     = pos_reg + 6'd1;
                    end
                    if (s_has_byte && pos_reg == sha256_pkg::LAST_POS)
                        state_next = ST_LOAD;
                    else if (s_last)
                        state_next = ST_PAD;
                end
            end

            ST_PAD:
            begin
                cmd.shift_en = 1'b1;
                pos_next     = pos_reg + 6'd1;
                if (!mark_reg)
                begin
                    cmd.byte_sel = sha256_pkg::SEL_MARK;
                    mark_next    = 1'b1;
                    len_ok_next  = (pos_reg < sha256_pkg::LENGTH_POS);
                end
                else if (len_ok_reg && pos_reg >= sha256_pkg::LENGTH_POS)
                    cmd.byte_sel = sha256_pkg::SEL_LEN;
                else
                    cmd.byte_sel = sha256_pkg::SEL_ZERO;
                if (pos_reg == sha256_pkg::LAST_POS)
                    state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                cmd.load_vars = 1'b1;
                round_next    = '0;
                state_next    = ST_ROUND;
            end

            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == sha256_pkg::LAST_ROUND)
                    state_next = ST_UPDATE;
            end

            ST_UPDATE:
            begin
                cmd.hash_add = 1'b1;
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (mark_reg && len_ok_reg)
                begin
                    out_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    // a further padding block carries the length
                    if (mark_reg)
                        len_ok_next = 1'b1;
                    state_next = ST_PAD;
                end
            end

            ST_OUT:
            begin
                m_valid = 1'b1;
                if (m_ready)
                begin
                    out_next = out_reg + 3'd1;
                    if (out_reg == sha256_pkg::LAST_INDEX)
                    begin
                        cmd.restart = 1'b1;
                        last_next   = 1'b0;
                        mark_next   = 1'b0;
                        len_ok_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sha256_dp.sv =====
// ----------------------------------------------------------------------------
// sha256_dp: datapath of the sha-256 digest block
// Message window as a 16-word shift line, round variables a..h, hash words
// and the message byte count; one compression round per cycle.
// ----------------------------------------------------------------------------
module sha256_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sha256_pkg::sha256_cmd_t cmd,
    input  logic [7:0]              data_byte,
    output logic [31:0]             digest_word
);

    logic [31:0] win_reg  [16];
    logic [31:0] var_reg  [8];
    logic [31:0] hash_reg [8];
    logic [60:0] cnt_reg;

    logic [63:0] len_bits;
    logic [63:0] len_shift;
    logic [7:0]  in_byte;
    logic [31:0] sig0, sig1, w_next;
    logic [31:0] big0, big1, ch, maj, t1, t2;

    // byte entering the window
    assign len_bits  = {cnt_reg, 3'b000};
    assign len_shift = len_bits >> {~cmd.pos_lo, 3'b000};

    always_comb
    begin
        case (cmd.byte_sel)
            sha256_pkg::SEL_DATA: in_byte = data_byte;
            sha256_pkg::SEL_MARK: in_byte = sha256_pkg::PAD_MARK;
            sha256_pkg::SEL_LEN:  in_byte = len_shift[7:0];
            default:              in_byte = 8'h00;
        endcase
    end

    // message schedule, word 16 ahead of the one in use
    assign sig0 = sha256_pkg::rotr(win_reg[1], 7) ^ sha256_pkg::rotr(win_reg[1], 18)
                ^ (win_reg[1] >> 3);
    assign sig1 = sha256_pkg::rotr(win_reg[14], 17) ^ sha256_pkg::rotr(win_reg[14], 19)
                ^ (win_reg[14] >> 10);
    assign w_next = win_reg[0] + sig0 + win_reg[9] + sig1;

    // one compression round
    assign big1 = sha256_pkg::rotr(var_reg[4], 6) ^ sha256_pkg::rotr(var_reg[4], 11)
                ^ sha256_pkg::rotr(var_reg[4], 25);
    assign ch   = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign t1   = var_reg[7] + big1 + ch + sha256_pkg::round_const(cmd.round_idx)
                + win_reg[0];
    assign big0 = sha256_pkg::rotr(var_reg[0], 2) ^ sha256_pkg::rotr(var_reg[0], 13)
                ^ sha256_pkg::rotr(var_reg[0], 22);
    assign maj  = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                ^ (var_reg[1] & var_reg[2]);
    assign t2   = big0 + maj;

    // message window: byte shift on fill, word shift on rounds
    always_ff @(posedge clk)
    begin
        if (cmd.shift_en)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= {win_reg[i][23:0], win_reg[i + 1][31:24]};
            win_reg[15] <= {win_reg[15][23:0], in_byte};
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= w_next;
        end
    end

    // round variables a..h
    always_ff @(posedge clk)
    begin
        if (cmd.load_vars)
        begin
            for (int i = 0; i < 8; i++)
                var_reg[i] <= hash_reg[i];
        end
        else if (cmd.round_en)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    // hash words and message byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= sha256_pkg::H_INIT[i];
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= sha256_pkg::H_INIT[i];
                cnt_reg <= '0;
            end
            else
            begin
                if (cmd.hash_add)
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + var_reg[i];
                end
                if (cmd.cnt_inc)
                    cnt_reg <= cnt_reg + 61'd1;
            end
        end
    end

    assign digest_word = hash_reg[cmd.out_idx];

endmodule

// ===== rtl/sha256_message_digest_top.sv =====
// ----------------------------------------------------------------------------
// sha256_message_digest_top: sha-256 digest over a byte stream
// Input requests carry an optional message byte and an end mark; after the
// end mark the eight big-endian digest words leave on the output stream.
// ----------------------------------------------------------------------------
// a byte request is taken while idle; the 64th byte of a block starts a compression
// (load, 64 rounds at one per cycle, hash update); an end request with pos bytes in its
// last block (0 to 63) pads it and compresses it, plus a second padded block when the
// length does not fit (pos of 56 or more), then the 8 digest words go out
// throughput: one request at a time, set by the single round unit
// reset: asynchronous active low; hash words, length and sequencer clear at once
module sha256_message_digest_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast    // last_word
);

    sha256_pkg::sha256_cmd_t cmd;
    logic [31:0]             digest_word;

    // sequencer
    sha256_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_has_byte (s_tuser),
        .s_last     (s_tlast),
        .s_ready    (s_tready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .cmd        (cmd)
    );

    // datapath
    sha256_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .digest_word (digest_word)
    );

    // output packing
    assign m_tdata = {5'b00000, cmd.out_idx, digest_word};
    assign m_tlast = (cmd.out_idx == sha256_pkg::LAST_INDEX);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output open at once");

    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after end of message");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("block not idle after final digest word");

    a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round_en && cmd.round_idx != sha256_pkg::LAST_ROUND |=> cmd.round_en)
        else $error("compression stopped early");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream-level check of the sha-256 message digest block
// Feeds whole messages one byte request at a time, with idle requests mixed
// in, and compares each digest word that leaves the block against a
// software sha-256 kept in a small scoreboard class. Message lengths lean
// toward the padding boundaries (one or two final compressions). The sender
// runs in random bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEM_TARGET  = 120;
    localparam int MSG_TARGET   = 6;

    // message lengths around the padding boundaries
    localparam int EDGE_LENS [11] = '{0, 1, 2, 55, 56, 57, 63, 64, 65, 119, 120};

    // sha-256 round constants
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } digest_word_t;

    typedef enum logic [1:0] {RX_FLOW, RX_RANDOM, RX_STARVE} rx_mode_t;

    // ------------------------------------------------------------------------
    // digest scoreboard: running sha-256 of the current message and the
    // queue of digest words still owed by the block
    // ------------------------------------------------------------------------
    class digest_scoreboard;
        logic [31:0]  chain [8];
        logic [7:0]   blk [64];
        logic [60:0]  msg_bytes;
        digest_word_t owed [$];
        int           errors;

        function new();
            restart();
            errors = 0;
        endfunction

        function void restart();
            foreach (chain[i])
                chain[i] = sha256_pkg::H_INIT[i];
            msg_bytes = '0;
        endfunction

        function logic [31:0] ror32(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // one 64-round compression of blk into chain
        function void compress();
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, h;
            logic [31:0] t1, t2, s0, s1;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
            for (int i = 0; i < 64; i++)
            begin
                s1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
                t1 = h + s1 + ((e & f) ^ (~e & g)) + ROUND_K[i] + w[i];
                s0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
                t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        // accepted input request: absorb the byte, finish the message on end
        function void note_request(logic [7:0] data, logic has_byte, logic last_item);
            int          pos;
            logic [63:0] bit_len;
            digest_word_t dw;
            if (has_byte)
            begin
                blk[msg_bytes[5:0]] = data;
                msg_bytes = msg_bytes + 61'd1;
                if (msg_bytes[5:0] == 6'd0)
                    compress();
            end
            if (!last_item)
                return;
            // pad mark, zero fill, and an extra block when the length won't fit
            pos = int'(msg_bytes[5:0]);
            blk[pos] = sha256_pkg::PAD_MARK;
            for (int k = pos + 1; k < 64; k++)
                blk[k] = 8'h00;
            if (pos >= int'(sha256_pkg::LENGTH_POS))
            begin
                compress();
                foreach (blk[k])
                    blk[k] = 8'h00;
            end
            bit_len = {msg_bytes, 3'b000};
            for (int k = 0; k < 8; k++)
                blk[int'(sha256_pkg::LENGTH_POS) + k] = bit_len[63 - 8*k -: 8];
            compress();
            for (int k = 0; k < 8; k++)
            begin
                dw.word = chain[k];
                dw.idx  = 3'(k);
                dw.fin  = (3'(k) == sha256_pkg::LAST_INDEX);
                owed.push_back(dw);
            end
            restart();
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        // accepted output request: compare with the oldest owed digest word
        function void check_word(logic [39:0] tdata, logic tlast);
            digest_word_t dw;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected digest word, expected none, actual %h",
                         $time, tdata);
                errors++;
                return;
            end
            dw = owed.pop_front();
            report("digest_word", dw.word, tdata[31:0]);
            report("word_index", 32'(dw.idx), 32'(tdata[34:32]));
            report("last_word", 32'(dw.fin), 32'(tlast));
            report("zero fill", 32'h0, 32'(tdata[39:35]));
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    digest_scoreboard sb = new();
    int       burst_left = 0;
    int       items_sent = 0;
    int       msgs_sent  = 0;
    int       cycles     = 0;
    int       rx_left    = 0;
    rx_mode_t rx_mode    = RX_FLOW;

    sha256_message_digest_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_request(s_tdata, s_tuser, s_tlast);
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tlast);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver stall pattern: free flow, coin flips, or long stalls
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(4, 40);
        end
        rx_left--;
        case (rx_mode)
            RX_FLOW:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            default:   m_tready <= (rx_left % 12 == 0);
        endcase
    end

    // one input request; called at a falling edge, returns at a falling edge
    task automatic send_request(logic [7:0] data, logic has_byte, logic last_item);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= last_item;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_idle();
        send_request(8'($urandom), 1'b0, 1'b0);
    endtask

    // whole message of random bytes, ending with or without a byte on the end mark
    task automatic send_message(int len, bit end_on_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_idle();
            send_request(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte || len == 0)
            send_request(8'($urandom), 1'b0, 1'b1);
        msgs_sent++;
    endtask

    initial
    begin
        int len;
        int pick;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty message after an idle request
        send_idle();
        send_request(8'h00, 1'b0, 1'b1);
        // single bytes at both extremes, byte and end together
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
        // "abc"
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        // byte, idle, then end without byte
        send_request(8'h5a, 1'b1, 1'b0);
        send_idle();
        send_request(8'ha5, 1'b0, 1'b1);
        send_idle();
        send_idle();

        // random messages, weighted toward the padding boundaries
        while (items_sent < ITEM_TARGET || msgs_sent < MSG_TARGET)
        begin
            if ($urandom_range(0, 4) < 2)
            begin
                pick = $urandom_range(0, 10);
                len = EDGE_LENS[pick];
            end
            else
                len = $urandom_range(0, 40);
            send_message(len, 1'($urandom_range(0, 1)));
        end
        s_tvalid <= 1'b0;

        // drain, then watch for stray output
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
